FILE: rtl/decimal_text_to_fixed_point_core_assert.svh
// Assertion macros for the decimal text to fixed-point converter.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_CORE_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define DTFP_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Condition implies a consequence in the same cycle.
`define DTFP_ASSERT_IMPLIES(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Condition implies a consequence in the next cycle.
`define DTFP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/dtfp_pkg.sv
// Constants, tables and types for the decimal text to fixed-point converter.
package dtfp_pkg;

  localparam int REM_W = 30;   // holds values below 10^9
  localparam int SUM_W = 34;   // holds values below 10^10
  localparam int WGT_W = 32;   // holds 2^FRAC_BITS / 10 and below

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] PH_BLANKS   = 2'd0;
  localparam logic [1:0] PH_INTEGER  = 2'd1;
  localparam logic [1:0] PH_FRACTION = 2'd2;
  localparam logic [1:0] PH_ENDED    = 2'd3;

  localparam logic [REM_W-1:0] TEN_POW [10] = '{
    30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
    30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
  };

  typedef logic [9:0][9:0][SUM_W-1:0] mul_tab_t;
  typedef logic [9:0][WGT_W-1:0]      wgt_tab_t;
  typedef logic [9:0][REM_W-1:0]      rem_tab_t;

  // Row k, column j holds j * 10^k.
  function automatic mul_tab_t build_ten_mul();
    mul_tab_t t;
    for (int k = 0; k < 10; k++) begin
      for (int j = 0; j < 10; j++) begin
        t[k][j] = SUM_W'(TEN_POW[k]) * SUM_W'(j);
      end
    end
    return t;
  endfunction

  // Entry k holds floor(2^fb / 10^k); entry zero is unused.
  function automatic wgt_tab_t build_weight(input int fb);
    wgt_tab_t t;
    t[0] = '0;
    for (int k = 1; k < 10; k++) begin
      t[k] = WGT_W'((64'(1) << fb) / 64'(TEN_POW[k]));
    end
    return t;
  endfunction

  // Entry k holds 2^fb mod 10^k; entry zero is unused.
  function automatic rem_tab_t build_rem(input int fb);
    rem_tab_t t;
    t[0] = '0;
    for (int k = 1; k < 10; k++) begin
      t[k] = REM_W'((64'(1) << fb) % 64'(TEN_POW[k]));
    end
    return t;
  endfunction

endpackage

FILE: rtl/decimal_text_to_fixed_point_core.sv
// Streaming decimal text to signed fixed-point converter, top level.
// A last request passes the input, snapshot and result stages in that order.
// Throughput: one character per cycle while input does not stall; the fraction digit step
// (table-weighted add, nine compares against multiples of a power of ten) sets cycle time.
// Three registered stages (input, snapshot, result) each stall only when the next is full.
// Reset: synchronous active-low rst_n clears valid bits and parser state; data is not reset.
`include "decimal_text_to_fixed_point_core_assert.svh"

module decimal_text_to_fixed_point_core
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS   = 32,
  parameter int INT_BITS    = 31,
  parameter int FRAC_DIGITS = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] out_value,
  output logic        out_saturated
);

  localparam mul_tab_t TEN_MUL = build_ten_mul();
  localparam wgt_tab_t WGT_TAB = build_weight(FRAC_BITS);
  localparam rem_tab_t REM_TAB = build_rem(FRAC_BITS);
  localparam logic [INT_BITS-1:0] INT_LIM   = {INT_BITS{1'b1}};
  localparam logic [INT_BITS+3:0] INT_LIM_W = {4'b0, {INT_BITS{1'b1}}};
  localparam logic [3:0] FRAC_DIGITS_C = 4'(FRAC_DIGITS);

  // Input stage
  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // Parser state
  logic [1:0]          phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic [INT_BITS-1:0] int_r, int_nxt;
  logic [FRAC_BITS-1:0] q_r, q_nxt;
  logic [REM_W-1:0]    rm_r, rm_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;

  // Snapshot stage
  logic        s2_v_r, s2_v_nxt;
  logic [63:0] s2_mag_r;
  logic        s2_neg_r;
  logic        s2_ovf_r;

  // Result stage
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r;
  logic        out_saturated_r;

  logic out_ld, s2_ld, s1_go, in_fire;

  assign out_ld   = !out_valid_r || out_ready;
  assign s2_ld    = !s2_v_r || out_ld;
  assign s1_go    = s1_v_r && (!s1_last_r || s2_ld);
  assign in_ready = !s1_v_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_saturated_r;

  // Character classes and digit value
  logic       is_blank, is_digit, is_sign;
  logic [3:0] dig;

  assign is_blank = (s1_char_r >= CH_TAB && s1_char_r <= CH_CR) || s1_char_r == CH_SPACE;
  assign is_digit = s1_char_r >= CH_ZERO && s1_char_r <= CH_NINE;
  assign is_sign  = s1_char_r == CH_MINUS || s1_char_r == CH_PLUS;
  assign dig      = 4'(s1_char_r - CH_ZERO);

  // Integer digit: multiply by ten, add, clamp
  logic [INT_BITS+3:0] int_ext, int_wide;
  logic [INT_BITS-1:0] int_dig;
  logic                ovf_dig;

  assign int_ext  = {4'b0, int_r};
  assign int_wide = (int_ext << 3) + (int_ext << 1) + {{INT_BITS{1'b0}}, dig};

  always_comb begin
    if (ovf_r || int_wide > INT_LIM_W) begin
      int_dig = INT_LIM;
      ovf_dig = 1'b1;
    end else begin
      int_dig = int_wide[INT_BITS-1:0];
      ovf_dig = 1'b0;
    end
  end

  // Fraction digit: keep value as q + rm / 10^cnt, exact
  logic             frac_ok;
  logic [3:0]       kidx;
  logic [SUM_W-1:0] rm_ext, num;
  logic [3:0]       carry;
  logic [REM_W-1:0] rm_dig;
  logic [FRAC_BITS-1:0] q_dig;

  assign frac_ok = cnt_r < FRAC_DIGITS_C;
  assign kidx    = frac_ok ? cnt_r + 4'd1 : 4'd1;
  assign rm_ext  = SUM_W'(rm_r);
  assign num     = (rm_ext << 3) + (rm_ext << 1) + SUM_W'(dig) * SUM_W'(REM_TAB[kidx]);

  always_comb begin
    carry = '0;
    for (int j = 1; j < 10; j++) begin
      if (num >= TEN_MUL[kidx][j]) begin
        carry = 4'(j);
      end
    end
  end

  assign rm_dig = REM_W'(num - TEN_MUL[kidx][carry]);
  assign q_dig  = q_r + FRAC_BITS'(36'(dig) * 36'(WGT_TAB[kidx][FRAC_BITS-1:0]))
                + FRAC_BITS'(carry);

  // Parser step for the character in the input stage
  logic [1:0]           t_phase;
  logic                 t_neg;
  logic [INT_BITS-1:0]  t_int;
  logic [FRAC_BITS-1:0] t_q;
  logic [REM_W-1:0]     t_rm;
  logic [3:0]           t_cnt;
  logic                 t_ovf;

  always_comb begin
    t_phase = phase_r;
    t_neg   = neg_r;
    t_int   = int_r;
    t_q     = q_r;
    t_rm    = rm_r;
    t_cnt   = cnt_r;
    t_ovf   = ovf_r;
    unique case (phase_r)
      PH_BLANKS: begin
        priority if (is_blank) begin
          t_phase = PH_BLANKS;
        end else if (is_sign) begin
          t_neg   = s1_char_r == CH_MINUS;
          t_phase = PH_INTEGER;
        end else if (is_digit) begin
          t_int   = int_dig;
          t_ovf   = ovf_dig;
          t_phase = PH_INTEGER;
        end else if (s1_char_r == CH_POINT) begin
          t_phase = PH_FRACTION;
        end else begin
          t_phase = PH_ENDED;
        end
      end
      PH_INTEGER: begin
        priority if (is_digit) begin
          t_int = int_dig;
          t_ovf = ovf_dig;
        end else if (s1_char_r == CH_POINT) begin
          t_phase = PH_FRACTION;
        end else begin
          t_phase = PH_ENDED;
        end
      end
      PH_FRACTION: begin
        priority if (is_digit) begin
          // drop digits beyond the kept count
          if (frac_ok) begin
            t_q   = q_dig;
            t_rm  = rm_dig;
            t_cnt = cnt_r + 4'd1;
          end
        end else begin
          t_phase = PH_ENDED;
        end
      end
      PH_ENDED: begin
        t_phase = PH_ENDED;
      end
      default: begin
        t_phase = PH_ENDED;
      end
    endcase
  end

  // Commit the step; a last request returns the parser to its reset state
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    int_nxt   = int_r;
    q_nxt     = q_r;
    rm_nxt    = rm_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    if (s1_go) begin
      if (s1_last_r) begin
        phase_nxt = PH_BLANKS;
        neg_nxt   = 1'b0;
        int_nxt   = '0;
        q_nxt     = '0;
        rm_nxt    = '0;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else begin
        phase_nxt = t_phase;
        neg_nxt   = t_neg;
        int_nxt   = t_int;
        q_nxt     = t_q;
        rm_nxt    = t_rm;
        cnt_nxt   = t_cnt;
        ovf_nxt   = t_ovf;
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s1_go && s1_last_r) begin
      s2_v_nxt = 1'b1;
    end else if (out_ld) begin
      s2_v_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = out_ld ? s2_v_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_BLANKS;
      neg_r       <= 1'b0;
      int_r       <= '0;
      q_r         <= '0;
      rm_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      int_r       <= int_nxt;
      q_r         <= q_nxt;
      rm_r        <= rm_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last;
    end
    if (s1_go && s1_last_r) begin
      s2_mag_r <= (64'(t_int) << FRAC_BITS) | 64'(t_q);
      s2_neg_r <= t_neg;
      s2_ovf_r <= t_ovf;
    end
    if (out_ld && s2_v_r) begin
      out_value_r     <= s2_neg_r ? 64'd0 - s2_mag_r : s2_mag_r;
      out_saturated_r <= s2_ovf_r;
    end
  end

  `DTFP_ASSERT_IMPLIES(a_ovf_clamps, ovf_r, int_r == INT_LIM,
    "integer flagged saturated but not at its limit")
  `DTFP_ASSERT_HOLDS(a_rem_below_weight, cnt_r <= FRAC_DIGITS_C && rm_r < TEN_POW[cnt_r],
    "fraction remainder not below its power of ten")
  `DTFP_ASSERT_IMPLIES(a_blank_clean, phase_r == PH_BLANKS,
    !neg_r && int_r == '0 && q_r == '0 && cnt_r == '0 && !ovf_r,
    "parser state not clear while skipping blanks")
  `DTFP_ASSERT_NEXT(a_last_to_snapshot, s1_go && s1_last_r, s2_v_r,
    "last request did not reach the snapshot stage")
  `DTFP_ASSERT_NEXT(a_snapshot_to_out, s2_v_r && out_ld, out_valid_r,
    "snapshot did not move to the result stage")

endmodule
